### rtl/kpc_pkg.sv
// Package for the key press classifier: word types, register map and codes.
package kpc_pkg;

    typedef struct packed {
        logic kind;
        logic key_down;
    } kpc_item_t;

    typedef struct packed {
        logic short_press;
        logic long_press;
        logic wheel_move;
        logic keydown_send;
        logic keydown_port;
        logic led_off;
        logic window_open;
    } kpc_result_t;

    localparam logic KIND_TICK = 1'b0;
    localparam logic KIND_EDGE = 1'b1;

    localparam int unsigned ADDR_W = 5;
    localparam int unsigned DATA_W = 32;

    typedef enum logic [2:0] {
        REG_LINK_SELECT     = 3'd0,
        REG_LONG_HOLD_TICKS = 3'd1,
        REG_SHORT_MIN_TICKS = 3'd2,
        REG_UP_WINDOW_TICKS = 3'd3,
        REG_BLINK_DIV       = 3'd4
    } kpc_reg_t;

    localparam logic [7:0] LONG_HOLD_RST = 8'd200;
    localparam logic [7:0] SHORT_MIN_RST = 8'd5;
    localparam logic [7:0] UP_WINDOW_RST = 8'd50;
    localparam logic [7:0] BLINK_DIV_RST = 8'd5;
    localparam logic [7:0] COUNT_MAX     = 8'hFF;

endpackage

### rtl/key_press_classifier.sv
// Key press classifier: short/long press detection from ticks and press edges.
//
//   channel   direction  handshake              payload
//   item      in         item_valid/item_stall  kpc_item_t   (kind, key_down)
//   result    out        result_valid/result_stall kpc_result_t (7 flags)
//   config    in         APB psel/penable/pready  5 registers at 4*i
//
// One word per cycle while item_stall is low: state is updated as the word is taken and
// the result word is registered on the same edge.
// item_stall is high only while a result word waits and result_stall is high.
// rst_n clears all state; the LED level resets to 1 (off), registers to defaults.
module key_press_classifier (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        item_valid,
    output logic                        item_stall,
    input  kpc_pkg::kpc_item_t          item,
    output logic                        result_valid,
    input  logic                        result_stall,
    output kpc_pkg::kpc_result_t        result,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [kpc_pkg::ADDR_W-1:0]  paddr,
    input  logic [kpc_pkg::DATA_W-1:0]  pwdata,
    output logic [kpc_pkg::DATA_W-1:0]  prdata,
    output logic                        pready
);

    logic       link_sel_reg;
    logic [7:0] long_hold_reg;
    logic [7:0] short_min_reg;
    logic [7:0] up_window_reg;
    logic [7:0] blink_div_reg;

    logic       armed_reg,    armed_next;
    logic [7:0] hold_reg,     hold_next;
    logic       short_reg,    short_next;
    logic       long_reg,     long_next;
    logic       sent_reg,     sent_next;
    logic [7:0] blink_reg,    blink_next;
    logic       led_reg,      led_next;
    logic       wheel_reg,    wheel_next;
    logic       win_reg,      win_next;
    logic [7:0] win_cnt_reg,  win_cnt_next;
    logic       send;

    logic                 result_valid_reg;
    kpc_pkg::kpc_result_t result_reg;

    logic                 take;
    logic                 cfg_wr;
    kpc_pkg::kpc_reg_t    cfg_idx;

    assign pready       = 1'b1;
    assign cfg_wr       = psel && penable && pwrite;
    assign cfg_idx      = kpc_pkg::kpc_reg_t'(paddr[4:2]);
    assign item_stall   = result_valid_reg && result_stall;
    assign take         = item_valid && !item_stall;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    always_comb
    begin
        prdata = '0;
        unique case (cfg_idx)
            kpc_pkg::REG_LINK_SELECT:     prdata[0]   = link_sel_reg;
            kpc_pkg::REG_LONG_HOLD_TICKS: prdata[7:0] = long_hold_reg;
            kpc_pkg::REG_SHORT_MIN_TICKS: prdata[7:0] = short_min_reg;
            kpc_pkg::REG_UP_WINDOW_TICKS: prdata[7:0] = up_window_reg;
            kpc_pkg::REG_BLINK_DIV:       prdata[7:0] = blink_div_reg;
            default:                      prdata = '0;
        endcase
    end

    always_comb
    begin
        armed_next   = armed_reg;
        hold_next    = hold_reg;
        short_next   = short_reg;
        long_next    = long_reg;
        sent_next    = sent_reg;
        blink_next   = blink_reg;
        led_next     = led_reg;
        wheel_next   = wheel_reg;
        win_next     = win_reg;
        win_cnt_next = win_cnt_reg;
        send         = 1'b0;

        if (item.kind == kpc_pkg::KIND_EDGE)
        begin
            armed_next = 1'b1;
        end
        else
        begin
            if (short_reg)
            begin
                wheel_next = 1'b1;
            end

            if (long_reg)
            begin
                blink_next = blink_reg + 8'd1;
                if (!sent_reg)
                begin
                    send      = 1'b1;
                    sent_next = 1'b1;
                end
                if (blink_next == blink_div_reg)
                begin
                    blink_next = 8'd0;
                    led_next   = !led_reg;
                end
            end

            if (armed_reg)
            begin
                armed_next = 1'b0;
                hold_next  = 8'd0;
                if (item.key_down)
                begin
                    if (hold_reg <= long_hold_reg && hold_reg != kpc_pkg::COUNT_MAX)
                    begin
                        armed_next = 1'b1;
                        hold_next  = hold_reg + 8'd1;
                    end
                    else
                    begin
                        short_next = 1'b0;
                        long_next  = 1'b1;
                        sent_next  = 1'b0;
                    end
                end
                else if (hold_reg > short_min_reg)
                begin
                    short_next = 1'b1;
                    long_next  = 1'b0;
                    win_next   = 1'b1;
                end
                else
                begin
                    short_next = 1'b0;
                    long_next  = 1'b0;
                end
            end

            if (win_next)
            begin
                if (win_cnt_reg == kpc_pkg::COUNT_MAX)
                begin
                    win_cnt_next = 8'd0;
                    win_next     = 1'b0;
                end
                else
                begin
                    win_cnt_next = win_cnt_reg + 8'd1;
                end
            end
            if (win_cnt_next > up_window_reg)
            begin
                win_cnt_next = 8'd0;
                win_next     = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            link_sel_reg  <= 1'b0;
            long_hold_reg <= kpc_pkg::LONG_HOLD_RST;
            short_min_reg <= kpc_pkg::SHORT_MIN_RST;
            up_window_reg <= kpc_pkg::UP_WINDOW_RST;
            blink_div_reg <= kpc_pkg::BLINK_DIV_RST;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                kpc_pkg::REG_LINK_SELECT:     link_sel_reg  <= pwdata[0];
                kpc_pkg::REG_LONG_HOLD_TICKS: long_hold_reg <= pwdata[7:0];
                kpc_pkg::REG_SHORT_MIN_TICKS: short_min_reg <= pwdata[7:0];
                kpc_pkg::REG_UP_WINDOW_TICKS: up_window_reg <= pwdata[7:0];
                kpc_pkg::REG_BLINK_DIV:       blink_div_reg <= pwdata[7:0];
                default:                      ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            armed_reg        <= 1'b0;
            hold_reg         <= 8'd0;
            short_reg        <= 1'b0;
            long_reg         <= 1'b0;
            sent_reg         <= 1'b0;
            blink_reg        <= 8'd0;
            led_reg          <= 1'b1;
            wheel_reg        <= 1'b0;
            win_reg          <= 1'b0;
            win_cnt_reg      <= 8'd0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                armed_reg   <= armed_next;
                hold_reg    <= hold_next;
                short_reg   <= short_next;
                long_reg    <= long_next;
                sent_reg    <= sent_next;
                blink_reg   <= blink_next;
                led_reg     <= led_next;
                wheel_reg   <= wheel_next;
                win_reg     <= win_next;
                win_cnt_reg <= win_cnt_next;
            end
            if (take)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            result_reg.short_press  <= short_next;
            result_reg.long_press   <= long_next;
            result_reg.wheel_move   <= wheel_next;
            result_reg.keydown_send <= send;
            result_reg.keydown_port <= link_sel_reg;
            result_reg.led_off      <= led_next;
            result_reg.window_open  <= win_next;
        end
    end

endmodule

### dv/kpc_checker.sv
// Checker for the key press classifier: predicts each result word and compares it.
`timescale 1ns / 1ps

module kpc_checker (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         item_valid,
    input  logic                         item_stall,
    input  kpc_pkg::kpc_item_t           item,
    input  logic                         result_valid,
    input  logic                         result_stall,
    input  kpc_pkg::kpc_result_t         result,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic                         pready,
    input  logic [kpc_pkg::ADDR_W-1:0]   paddr,
    input  logic [kpc_pkg::DATA_W-1:0]   pwdata,
    output int                           mismatches,
    output int                           words_owed,
    output int                           words_checked
);

    logic       link_sel;
    logic [7:0] long_thr;
    logic [7:0] short_thr;
    logic [7:0] win_lim;
    logic [7:0] blink_div;

    logic       armed;
    logic [7:0] hold_cnt;
    logic       short_f;
    logic       long_f;
    logic       kd_sent;
    logic [7:0] blink_cnt;
    logic       led;
    logic       wheel;
    logic       win_act;
    logic [7:0] win_cnt;

    kpc_pkg::kpc_result_t expected_flags [$];
    kpc_pkg::kpc_result_t want;

    function automatic void reset_model();
        link_sel  = 1'b0;
        long_thr  = kpc_pkg::LONG_HOLD_RST;
        short_thr = kpc_pkg::SHORT_MIN_RST;
        win_lim   = kpc_pkg::UP_WINDOW_RST;
        blink_div = kpc_pkg::BLINK_DIV_RST;
        armed     = 1'b0;
        hold_cnt  = '0;
        short_f   = 1'b0;
        long_f    = 1'b0;
        kd_sent   = 1'b0;
        blink_cnt = '0;
        led       = 1'b1;
        wheel     = 1'b0;
        win_act   = 1'b0;
        win_cnt   = '0;
    endfunction

    // one word in, the flag levels after it out
    function automatic kpc_pkg::kpc_result_t classify_word(kpc_pkg::kpc_item_t w);
        kpc_pkg::kpc_result_t r;
        r = '0;
        if (w.kind == kpc_pkg::KIND_EDGE)
        begin
            armed = 1'b1;
        end
        else
        begin
            if (short_f)
            begin
                wheel = 1'b1;
            end
            if (long_f)
            begin
                blink_cnt = blink_cnt + 8'd1;
                if (!kd_sent)
                begin
                    r.keydown_send = 1'b1;
                    kd_sent = 1'b1;
                end
                if (blink_cnt == blink_div)
                begin
                    blink_cnt = '0;
                    led = ~led;
                end
            end
            if (armed)
            begin
                armed = 1'b0;
                if (w.key_down)
                begin
                    if (hold_cnt <= long_thr && hold_cnt != kpc_pkg::COUNT_MAX)
                    begin
                        hold_cnt = hold_cnt + 8'd1;
                        armed = 1'b1;
                    end
                    else
                    begin
                        hold_cnt = '0;
                        short_f = 1'b0;
                        long_f = 1'b1;
                        kd_sent = 1'b0;
                    end
                end
                else
                begin
                    if (hold_cnt > short_thr)
                    begin
                        short_f = 1'b1;
                        long_f = 1'b0;
                        win_act = 1'b1;
                    end
                    else
                    begin
                        short_f = 1'b0;
                        long_f = 1'b0;
                    end
                    hold_cnt = '0;
                end
            end
            if (win_act)
            begin
                if (win_cnt == kpc_pkg::COUNT_MAX)
                begin
                    win_cnt = '0;
                    win_act = 1'b0;
                end
                else
                begin
                    win_cnt = win_cnt + 8'd1;
                end
            end
            if (win_cnt > win_lim)
            begin
                win_cnt = '0;
                win_act = 1'b0;
            end
        end
        r.short_press  = short_f;
        r.long_press   = long_f;
        r.wheel_move   = wheel;
        r.keydown_port = link_sel;
        r.led_off      = led;
        r.window_open  = win_act;
        return r;
    endfunction

    function automatic void check_field(string name, logic e, logic a);
        if (e !== a)
        begin
            $display("%0t: %s mismatch, expected %b got %b", $time, name, e, a);
            mismatches++;
        end
    endfunction

    initial
    begin
        reset_model();
        mismatches = 0;
        words_checked = 0;
        words_owed = 0;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reset_model();
            expected_flags.delete();
            words_owed <= 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[4:2])
                    kpc_pkg::REG_LINK_SELECT:     link_sel  = pwdata[0];
                    kpc_pkg::REG_LONG_HOLD_TICKS: long_thr  = pwdata[7:0];
                    kpc_pkg::REG_SHORT_MIN_TICKS: short_thr = pwdata[7:0];
                    kpc_pkg::REG_UP_WINDOW_TICKS: win_lim   = pwdata[7:0];
                    kpc_pkg::REG_BLINK_DIV:       blink_div = pwdata[7:0];
                    default: ;
                endcase
            end
            if (item_valid && !item_stall)
            begin
                expected_flags.push_back(classify_word(item));
            end
            if (result_valid && !result_stall)
            begin
                if (expected_flags.size() == 0)
                begin
                    $display("%0t: result word with none expected, expected none got %b",
                             $time, result);
                    mismatches++;
                end
                else
                begin
                    want = expected_flags.pop_front();
                    check_field("short_press",  want.short_press,  result.short_press);
                    check_field("long_press",   want.long_press,   result.long_press);
                    check_field("wheel_move",   want.wheel_move,   result.wheel_move);
                    check_field("keydown_send", want.keydown_send, result.keydown_send);
                    check_field("keydown_port", want.keydown_port, result.keydown_port);
                    check_field("led_off",      want.led_off,      result.led_off);
                    check_field("window_open",  want.window_open,  result.window_open);
                    words_checked++;
                end
            end
            words_owed <= expected_flags.size();
        end
    end

endmodule

### dv/tb_key_press_classifier.sv
// Testbench top for the key press classifier: stimulus, stalls and verdict.
`timescale 1ns / 1ps

module tb_key_press_classifier;

    localparam int RANDOM_WORDS = 600;

    typedef logic [kpc_pkg::DATA_W-1:0] word_t;

    logic                         clk = 1'b0;
    logic                         rst_n = 1'b0;
    logic                         item_valid = 1'b0;
    kpc_pkg::kpc_item_t           item = '0;
    logic                         result_stall = 1'b0;
    logic                         psel = 1'b0;
    logic                         penable = 1'b0;
    logic                         pwrite = 1'b0;
    logic [kpc_pkg::ADDR_W-1:0]   paddr = '0;
    word_t                        pwdata = '0;

    logic                         item_stall;
    logic                         result_valid;
    kpc_pkg::kpc_result_t         result;
    word_t                        prdata;
    logic                         pready;

    int fail_count;
    int owed;
    int checked;
    int words_sent = 0;
    int settings_run = 0;
    bit no_gaps = 1'b0;
    int stall_hold = 0;
    int stall_pick;
    logic [7:0] cur_long = kpc_pkg::LONG_HOLD_RST;

    initial
    begin
        forever #5 clk = ~clk;
    end

    key_press_classifier dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    kpc_checker chk (
        .clk           (clk),
        .rst_n         (rst_n),
        .item_valid    (item_valid),
        .item_stall    (item_stall),
        .item          (item),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .result        (result),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .pready        (pready),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .mismatches    (fail_count),
        .words_owed    (owed),
        .words_checked (checked)
    );

    // receiver stalls: mostly short bursts, some long, some stall-free stretches
    always @(posedge clk)
    begin
        if (stall_hold != 0)
        begin
            stall_hold <= stall_hold - 1;
        end
        else
        begin
            stall_pick = $urandom_range(0, 99);
            if (stall_pick < 60)
            begin
                result_stall <= 1'b0;
                stall_hold <= $urandom_range(0, 4);
            end
            else if (stall_pick < 90)
            begin
                result_stall <= 1'b1;
                stall_hold <= $urandom_range(0, 2);
            end
            else if (stall_pick < 96)
            begin
                result_stall <= 1'b0;
                stall_hold <= $urandom_range(20, 60);
            end
            else
            begin
                result_stall <= 1'b1;
                stall_hold <= $urandom_range(8, 30);
            end
        end
    end

    task automatic send_word(logic k, logic down);
        int gap;
        int pick;
        gap = 0;
        if (!no_gaps)
        begin
            pick = $urandom_range(0, 99);
            if (pick >= 92)
                gap = $urandom_range(8, 30);
            else if (pick >= 70)
                gap = $urandom_range(1, 3);
        end
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid <= 1'b1;
        item.kind <= k;
        item.key_down <= down;
        @(posedge clk);
        while (item_stall) @(posedge clk);
        words_sent++;
    endtask

    task automatic hold_and_release(int held, bit release_key);
        send_word(kpc_pkg::KIND_EDGE, 1'($urandom_range(0, 1)));
        repeat (held) send_word(kpc_pkg::KIND_TICK, 1'b1);
        if (release_key)
            send_word(kpc_pkg::KIND_TICK, 1'b0);
    endtask

    task automatic drain();
        item_valid <= 1'b0;
        @(posedge clk);
        while (owed != 0) @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_reg(kpc_pkg::kpc_reg_t r, word_t v);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {r, 2'b00};
        pwdata <= v;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
    endtask

    task automatic set_registers(logic link, logic [7:0] lh, logic [7:0] sm,
                                 logic [7:0] uw, logic [7:0] bd);
        write_reg(kpc_pkg::REG_LINK_SELECT, word_t'(link));
        write_reg(kpc_pkg::REG_LONG_HOLD_TICKS, word_t'(lh));
        write_reg(kpc_pkg::REG_SHORT_MIN_TICKS, word_t'(sm));
        write_reg(kpc_pkg::REG_UP_WINDOW_TICKS, word_t'(uw));
        write_reg(kpc_pkg::REG_BLINK_DIV, word_t'(bd));
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        cur_long = lh;
        settings_run++;
        @(posedge clk);
    endtask

    initial
    begin
        kpc_pkg::kpc_item_t opening [$];
        int rand_start;
        int seg_start;
        int pick;
        logic [7:0] sm;
        logic [7:0] uw;

        // long press, keydown send and LED blink, ignored press, short press, window closing
        opening = '{
            '{kpc_pkg::KIND_TICK, 1'b0}, '{kpc_pkg::KIND_TICK, 1'b1},
            '{kpc_pkg::KIND_EDGE, 1'b1}, '{kpc_pkg::KIND_TICK, 1'b1},
            '{kpc_pkg::KIND_TICK, 1'b1}, '{kpc_pkg::KIND_TICK, 1'b1},
            '{kpc_pkg::KIND_TICK, 1'b0}, '{kpc_pkg::KIND_TICK, 1'b0},
            '{kpc_pkg::KIND_EDGE, 1'b0}, '{kpc_pkg::KIND_TICK, 1'b0},
            '{kpc_pkg::KIND_EDGE, 1'b1}, '{kpc_pkg::KIND_TICK, 1'b1},
            '{kpc_pkg::KIND_TICK, 1'b0}, '{kpc_pkg::KIND_TICK, 1'b0},
            '{kpc_pkg::KIND_TICK, 1'b0}, '{kpc_pkg::KIND_EDGE, 1'b0},
            '{kpc_pkg::KIND_TICK, 1'b1}, '{kpc_pkg::KIND_TICK, 1'b1},
            '{kpc_pkg::KIND_TICK, 1'b1}, '{kpc_pkg::KIND_TICK, 1'b0},
            '{kpc_pkg::KIND_TICK, 1'b0}
        };

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_word(kpc_pkg::KIND_EDGE, 1'b1);
        send_word(kpc_pkg::KIND_TICK, 1'b0);
        drain();

        set_registers(1'b1, 8'd1, 8'd0, 8'd1, 8'd1);
        foreach (opening[i])
            send_word(opening[i].kind, opening[i].key_down);
        drain();

        rand_start = words_sent;

        // hold count saturates into a long press; window runs to its saturation
        set_registers(1'b1, kpc_pkg::COUNT_MAX, 8'd0, kpc_pkg::COUNT_MAX,
                      kpc_pkg::COUNT_MAX);
        no_gaps = ($urandom_range(0, 3) == 0);
        hold_and_release(1, 1'b1);
        hold_and_release(258, 1'b0);
        repeat (12) send_word(kpc_pkg::KIND_TICK, 1'($urandom_range(0, 1)));
        drain();

        // blink divider now below the count: it has to wrap round
        set_registers(1'b0, 8'd2, kpc_pkg::COUNT_MAX, 8'd1, 8'd3);
        no_gaps = ($urandom_range(0, 3) == 0);
        seg_start = words_sent;
        while (words_sent - seg_start < 300)
            hold_and_release($urandom_range(4, 10), 1'($urandom_range(0, 1)));
        drain();

        while (words_sent - rand_start < RANDOM_WORDS)
        begin
            sm = ($urandom_range(0, 7) == 0) ? kpc_pkg::COUNT_MAX
                                             : 8'($urandom_range(0, 6));
            uw = ($urandom_range(0, 7) == 0) ? kpc_pkg::COUNT_MAX
                                             : 8'($urandom_range(1, 20));
            set_registers(1'($urandom_range(0, 1)), 8'($urandom_range(1, 12)), sm, uw,
                          8'($urandom_range(1, 6)));
            no_gaps = ($urandom_range(0, 3) == 0);
            repeat ($urandom_range(6, 14))
            begin
                pick = $urandom_range(0, 9);
                if (pick < 6)
                begin
                    hold_and_release($urandom_range(0, cur_long + 3),
                                     $urandom_range(0, 4) != 0);
                end
                else if (pick < 8)
                begin
                    repeat ($urandom_range(1, 6))
                        send_word(kpc_pkg::KIND_TICK, 1'($urandom_range(0, 1)));
                end
                else if (pick < 9)
                begin
                    repeat ($urandom_range(1, 2))
                        send_word(kpc_pkg::KIND_EDGE, 1'($urandom_range(0, 1)));
                end
                else
                begin
                    drain();
                end
            end
            drain();
        end

        drain();
        $display("Sent %0d words (ticks and press edges) over %0d register settings,",
                 words_sent, settings_run);
        $display("covering short, long and ignored presses; %0d result words compared.",
                 checked);
        if (fail_count == 0 && owed == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("Timed out with %0d result words outstanding", owed);
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
